>>> hw/rtl/swma_pkg.sv
package swma_pkg;

    // Fixed field and bus widths.
    localparam int SAMPLE_W    = 8;
    localparam int WLEN_W      = 11;
    localparam int TWICE_W     = 9;
    localparam int TOTAL_W     = 32;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Register index decoded from paddr[2].
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic start;  // clear the accumulator before a new scan
        logic step;   // one histogram bin arrives this cycle
        logic last;   // that bin is the last one
    } t_scan_ctl;

endpackage

>>> hw/rtl/sliding_window_median_alert_core.sv
// Path: a sample still filling the window goes from idle through the increment read and write
// and finish states. A judged sample first runs the prefix scan and the decrement read and write,
// and the scan reads one bin per cycle from the histogram memory's single read port.
// Throughput: one sample at a time; the input is not ready until the result is registered.
// Reset (synchronous, active low) and every window_length write start a clearing pass over
// all VALUE_BINS bins of the histogram, during which no sample is accepted.
module sliding_window_median_alert_core
    import swma_pkg::*;
#(
    parameter int VALUE_BINS = 256,
    parameter int WINDOW_MAX = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sample input stream. tdata: sample[7:0].
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // Result stream. tdata: alert[0], twice_median[9:1], alert_total[41:10], zero[47:42].
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: judged[0].
    output logic                  m_axis_tuser,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Derived widths. A bin index, a delay-line slot, and a bin count, which never
    // exceeds the effective window length.
    localparam int BIN_W   = $clog2(VALUE_BINS);
    localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int DL_W    = (BIN_W < SAMPLE_W) ? BIN_W : SAMPLE_W;
    localparam int LEN_CAP = (WINDOW_MAX < 2047) ? WINDOW_MAX : 2047;
    localparam int CNT_W   = $clog2(LEN_CAP + 1);
    localparam int TW_W    = BIN_W + 1;
    localparam int CMP_W   = (TW_W > SAMPLE_W) ? TW_W : SAMPLE_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_INC_RD,
        ST_INC_WR,
        ST_FINISH
    } t_state;

    t_state r_state;

    // Configuration and window bookkeeping.
    logic [WLEN_W-1:0]  r_window_length;
    logic [CNT_W-1:0]   r_len;
    logic [CNT_W-1:0]   r_fill;
    logic [SLOT_W-1:0]  r_write_slot;
    logic [TOTAL_W-1:0] r_alerts;
    logic [BIN_W-1:0]   r_clr_addr;

    // The sample in flight.
    logic [SAMPLE_W-1:0] r_sample;
    logic [BIN_W-1:0]    r_bin;
    logic [SLOT_W-1:0]   r_slot;
    logic [BIN_W-1:0]    r_old;
    logic                r_judge;
    logic                r_alert;
    logic [TW_W-1:0]     r_twice;

    // Scan read pipeline: the address issued, and the bin whose count returns now.
    logic [BIN_W-1:0] r_scan_addr;
    logic [BIN_W-1:0] r_rd_idx;
    logic             r_rd_pend;

    // Registered result.
    logic                r_out_valid;
    logic                r_out_judged;
    logic                r_out_alert;
    logic [TWICE_W-1:0]  r_out_twice;
    logic [TOTAL_W-1:0]  r_out_total;

    logic              cfg_wr;
    logic [CNT_W-1:0]  eff_len;
    logic              accept;
    logic [BIN_W-1:0]  in_bin;
    logic [SLOT_W-1:0] cur_slot;
    logic [31:0]       slot_inc;
    logic [SLOT_W-1:0] next_slot;

    logic              hist_we;
    logic [BIN_W-1:0]  hist_waddr;
    logic [CNT_W-1:0]  hist_wdata;
    logic [BIN_W-1:0]  hist_raddr;
    logic [CNT_W-1:0]  hist_q;
    logic [DL_W-1:0]   dl_q;
    logic [BIN_W-1:0]  dl_bin;

    t_scan_ctl         scan_ctl;
    logic              scan_finish;
    logic [TW_W-1:0]   scan_twice;
    logic              new_alert;

    // ------------------------------------------------------------------
    // Configuration port. The only register is window_length; a write
    // restarts the window and launches a clearing pass.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? APB_DATA_W'(r_window_length) : '0;

    // Effective length: zero counts as one, and it saturates at the window depth or 2047, whichever is smaller.
    always_comb begin
        if (pwdata[WLEN_W-1:0] == '0) begin
            eff_len = CNT_W'(1);
        end else if (32'(pwdata[WLEN_W-1:0]) > LEN_CAP) begin
            eff_len = CNT_W'(LEN_CAP);
        end else begin
            eff_len = CNT_W'(pwdata[WLEN_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Input side. A sample is taken only in the idle state; values beyond
    // the last bin fold into it, while the compare uses the raw sample.
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (32'(s_axis_tdata[SAMPLE_W-1:0]) >= VALUE_BINS) begin
            in_bin = BIN_W'(VALUE_BINS - 1);
        end else begin
            in_bin = BIN_W'(s_axis_tdata[SAMPLE_W-1:0]);
        end
        cur_slot  = (32'(r_write_slot) >= 32'(r_len)) ? '0 : r_write_slot;
        slot_inc  = 32'(r_slot) + 32'd1;
        next_slot = (slot_inc >= 32'(r_len)) ? '0 : SLOT_W'(slot_inc);
    end

    // ------------------------------------------------------------------
    // Histogram memory. The sequencer time-shares its one read and one
    // write port between the clearing pass, the prefix scan, and the
    // read-modify-write of the outgoing and incoming bins.
    // ------------------------------------------------------------------
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_clr_addr;
        hist_wdata = '0;
        hist_raddr = r_scan_addr;
        unique case (r_state)
            ST_CLEAR: begin
                hist_we = 1'b1;
            end
            ST_DEC_RD: begin
                hist_raddr = dl_bin;
            end
            ST_DEC_WR: begin
                hist_we    = 1'b1;
                hist_waddr = r_old;
                hist_wdata = (hist_q != '0) ? hist_q - 1'b1 : hist_q;
            end
            ST_INC_RD: begin
                hist_raddr = r_bin;
            end
            ST_INC_WR: begin
                hist_we    = 1'b1;
                hist_waddr = r_bin;
                hist_wdata = hist_q + 1'b1;
            end
            default: begin
            end
        endcase
    end

    swma_ram #(
        .DEPTH  (VALUE_BINS),
        .ADDR_W (BIN_W),
        .DATA_W (CNT_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_q)
    );

    // Delay line of bin indexes. The read port keeps following the slot of the
    // sample in flight, so the outgoing sample is ready well before it is needed.
    // The new bin is written into that slot once the outgoing one has been read.
    swma_ram #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (SLOT_W),
        .DATA_W (DL_W)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_INC_WR),
        .i_waddr (r_slot),
        .i_wdata (DL_W'(r_bin)),
        .i_raddr (r_slot),
        .o_rdata (dl_q)
    );

    assign dl_bin = BIN_W'(dl_q);

    // ------------------------------------------------------------------
    // Prefix scan. One bin count enters the accumulate-and-compare unit per
    // cycle; it stops at the bin that reaches the upper middle rank, or at the last bin.
    // ------------------------------------------------------------------
    always_comb begin
        scan_ctl.start = accept;
        scan_ctl.step  = (r_state == ST_SCAN) && r_rd_pend;
        scan_ctl.last  = (32'(r_rd_idx) == (VALUE_BINS - 1));
    end

    swma_scan_unit #(
        .BIN_W (BIN_W),
        .CNT_W (CNT_W)
    ) u_scan (
        .i_clk    (i_clk),
        .i_ctl    (scan_ctl),
        .i_len    (r_len),
        .i_idx    (r_rd_idx),
        .i_count  (hist_q),
        .o_finish (scan_finish),
        .o_twice  (scan_twice)
    );

    assign new_alert = CMP_W'(r_sample) >= CMP_W'(scan_twice);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr_addr      <= '0;
            r_window_length <= WLEN_W'(1);
            r_len           <= CNT_W'(1);
            r_fill          <= '0;
            r_write_slot    <= '0;
            r_alerts        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            // In the finish state the result register is refilled instead.
            if (r_out_valid && m_axis_tready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_wr) begin
                r_window_length <= pwdata[WLEN_W-1:0];
                r_len           <= eff_len;
                r_fill          <= '0;
                r_write_slot    <= '0;
                r_clr_addr      <= '0;
                r_state         <= ST_CLEAR;
            end else begin
                unique case (r_state)
                    ST_CLEAR: begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                        if (32'(r_clr_addr) == (VALUE_BINS - 1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (accept) begin
                            r_sample    <= s_axis_tdata[SAMPLE_W-1:0];
                            r_bin       <= in_bin;
                            r_slot      <= cur_slot;
                            r_scan_addr <= '0;
                            r_rd_pend   <= 1'b0;
                            r_judge     <= (r_fill >= r_len);
                            if (r_fill >= r_len) begin
                                r_state <= ST_SCAN;
                            end else begin
                                // Still filling: no verdict, and the outgoing step is skipped.
                                r_fill  <= r_fill + 1'b1;
                                r_alert <= 1'b0;
                                r_twice <= '0;
                                r_state <= ST_INC_RD;
                            end
                        end
                    end
                    ST_SCAN: begin
                        r_scan_addr <= r_scan_addr + 1'b1;
                        r_rd_idx    <= r_scan_addr;
                        r_rd_pend   <= 1'b1;
                        if (scan_finish) begin
                            r_state <= ST_DEC_RD;
                        end
                    end
                    ST_DEC_RD: begin
                        r_old   <= dl_bin;
                        r_twice <= scan_twice;
                        r_alert <= new_alert;
                        if (new_alert && (r_alerts != TOTAL_MAX)) begin
                            r_alerts <= r_alerts + 1'b1;
                        end
                        r_state <= ST_DEC_WR;
                    end
                    ST_DEC_WR: begin
                        r_state <= ST_INC_RD;
                    end
                    ST_INC_RD: begin
                        r_state <= ST_INC_WR;
                    end
                    ST_INC_WR: begin
                        r_write_slot <= next_slot;
                        r_state      <= ST_FINISH;
                    end
                    ST_FINISH: begin
                        // Hold the result until the output register is free.
                        if (!r_out_valid || m_axis_tready) begin
                            r_out_valid  <= 1'b1;
                            r_out_judged <= r_judge;
                            r_out_alert  <= r_alert;
                            r_out_twice  <= TWICE_W'(r_twice);
                            r_out_total  <= r_alerts;
                            r_state      <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side.
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_judged;
    assign m_axis_tdata  = {{(M_TDATA_W - 1 - TWICE_W - TOTAL_W){1'b0}},
                            r_out_total, r_out_twice, r_out_alert};

endmodule

>>> hw/rtl/swma_ram.sv
module swma_ram
    import swma_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/swma_scan_unit.sv
module swma_scan_unit
    import swma_pkg::*;
#(
    parameter int BIN_W = 8,
    parameter int CNT_W = 11
) (
    input  logic             i_clk,
    input  t_scan_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_len,
    input  logic [BIN_W-1:0] i_idx,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_finish,
    output logic [BIN_W:0]   o_twice
);

    logic [CNT_W:0]   r_cum;
    logic             r_have_a;
    logic [BIN_W-1:0] r_a;
    logic [BIN_W-1:0] r_b;

    logic [CNT_W:0]   cum_n;
    logic [CNT_W:0]   lo_rank;
    logic [CNT_W:0]   hi_rank;
    logic             hit_a;
    logic             hit_b;

    // The two middle ranks coincide for an odd window.
    always_comb begin
        hi_rank = (CNT_W+1)'(i_len >> 1) + 1'b1;
        lo_rank = i_len[0] ? hi_rank : (CNT_W+1)'(i_len >> 1);
        cum_n   = r_cum + (CNT_W+1)'(i_count);
        hit_a   = !r_have_a && (cum_n >= lo_rank);
        hit_b   = cum_n >= hi_rank;
    end

    assign o_finish = i_ctl.step && (hit_b || i_ctl.last);
    assign o_twice  = (BIN_W+1)'(r_a) + (BIN_W+1)'(r_b);

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cum    <= '0;
            r_have_a <= 1'b0;
            r_a      <= '0;
            r_b      <= '0;
        end else if (i_ctl.step) begin
            r_cum <= cum_n;
            if (hit_a) begin
                r_a      <= i_idx;
                r_have_a <= 1'b1;
            end
            if (hit_b) begin
                r_b <= i_idx;
            end
        end
    end

endmodule

>>> hw/rtl/swma_checker.sv
module swma_checker
    import swma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic                  pready
);

    // Reset starts the clearing pass, so no sample is taken and no result shows.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!s_axis_tready && !m_axis_tvalid))
        else $error("sample accepted or result shown right after reset");

    // One sample at a time: the input closes after each transfer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second sample accepted while one is in flight");

    // A window_length write restarts the window with a clearing pass.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH))
        |=> !s_axis_tready)
        else $error("sample accepted during the clearing pass after a config write");

    // An unjudged result carries neither an alert nor a median.
    a_fill_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[TWICE_W:0] == '0))
        else $error("alert or median set on a sample that only fills the window");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind sliding_window_median_alert_core swma_checker u_swma_checker (.*);
